// ===== sv/fesb_pkg.sv =====
// Shared types and constants for the empty-frame screen blanker.
package fesb_pkg;

    localparam int unsigned LIT_W  = 22;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CFG_W  = 22;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned SUM_W  = 22;

    // Gray weights, Q14, plus rounding half
    localparam logic [SUM_W-1:0] GRAY_R_WEIGHT = 22'd4899;
    localparam logic [SUM_W-1:0] GRAY_G_WEIGHT = 22'd9617;
    localparam logic [SUM_W-1:0] GRAY_B_WEIGHT = 22'd1868;
    localparam logic [SUM_W-1:0] GRAY_ROUND    = 22'd8192;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [LIT_W-1:0] LIT_MAX = '1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PIXEL_LEVEL       = 3'd0;
    localparam logic [IDX_W-1:0] REG_PIXEL_COUNT_LIMIT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COARSE_RUN_EVERY  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COARSE_THRESHOLD  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FINE_RUN_EVERY    = 3'd4;
    localparam logic [IDX_W-1:0] REG_FINE_THRESHOLD    = 3'd5;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_COARSE = 2'd1,
        MODE_FINE   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] sample_cnt;
        logic [CNT_W-1:0] empty_run;
    } seq_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] coarse_run_every;
        logic [CNT_W-1:0] coarse_threshold;
        logic [CNT_W-1:0] fine_run_every;
        logic [CNT_W-1:0] fine_threshold;
    } seq_cfg_t;

    typedef struct packed {
        logic screen_blanked;
        logic turn_off;
        logic turn_on;
    } seq_flags_t;

endpackage

// ===== sv/fesb_seq.sv =====
// Frame sequencer: next mode, sample counter and empty run for one frame end.
module fesb_seq
    import fesb_pkg::*;
(
    input  seq_state_t state_cur,
    input  seq_cfg_t   cfg,
    input  logic       frame_empty,
    output seq_state_t state_nxt,
    output seq_flags_t flags
);

    typedef enum logic [1:0] {
        OUT_COUNTING,
        OUT_NOT_EMPTY,
        OUT_EMPTY
    } outcome_t;

    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] thresh;
    logic [CNT_W-1:0] sc_inc;
    logic [CNT_W-1:0] er_inc;
    logic [CNT_W-1:0] samp_sc;
    logic [CNT_W-1:0] samp_er;
    logic             hit;
    outcome_t         outcome;

    always_comb begin
        // coarse mode runs on the fine period and threshold
        period = (state_cur.mode == MODE_COARSE) ? cfg.fine_run_every : cfg.coarse_run_every;
        thresh = (state_cur.mode == MODE_COARSE) ? cfg.fine_threshold : cfg.coarse_threshold;
        sc_inc = (state_cur.sample_cnt == CNT_MAX) ? state_cur.sample_cnt
                                                   : state_cur.sample_cnt + 1'b1;
        er_inc = (state_cur.empty_run == CNT_MAX) ? state_cur.empty_run
                                                  : state_cur.empty_run + 1'b1;
        hit     = (sc_inc >= period);
        samp_sc = hit ? '0 : sc_inc;
        if (!hit) begin
            samp_er = state_cur.empty_run;
            outcome = OUT_COUNTING;
        end else if (!frame_empty) begin
            samp_er = '0;
            outcome = OUT_NOT_EMPTY;
        end else begin
            samp_er = er_inc;
            outcome = (er_inc >= thresh) ? OUT_EMPTY : OUT_COUNTING;
        end
    end

    always_comb begin
        state_nxt = state_cur;
        flags     = '0;
        unique case (state_cur.mode)
            MODE_NORMAL: begin
                state_nxt.sample_cnt = samp_sc;
                state_nxt.empty_run  = samp_er;
                if (outcome == OUT_EMPTY) begin
                    state_nxt.mode      = MODE_COARSE;
                    state_nxt.empty_run = '0;
                end
            end
            MODE_COARSE: begin
                state_nxt.sample_cnt = samp_sc;
                state_nxt.empty_run  = samp_er;
                if (outcome == OUT_EMPTY) begin
                    state_nxt.mode       = MODE_FINE;
                    flags.turn_off       = 1'b1;
                    flags.screen_blanked = 1'b1;
                end else if (outcome == OUT_NOT_EMPTY) begin
                    state_nxt.mode      = MODE_NORMAL;
                    state_nxt.empty_run = '0;
                end
            end
            MODE_FINE: begin
                if (frame_empty) begin
                    flags.screen_blanked = 1'b1;
                end else begin
                    state_nxt.mode      = MODE_NORMAL;
                    state_nxt.empty_run = '0;
                    flags.turn_on       = 1'b1;
                end
            end
            default: begin
                // unreachable code: hold everything
            end
        endcase
    end

endmodule

// ===== sv/frame_empty_screen_blanker.sv =====
// Top level of the empty-frame screen blanker: pixel pipeline, lit counter, result skid.
// Result path: last-pixel beat -> input reg -> gray/compare reg -> output reg -> m_.
// Throughput: one pixel beat per cycle; the three-stage pipe (input reg, gray/compare
//   reg, count/sequencer into the output reg) freezes only while the skid entry is full.
// Reset: synchronous active-low aresetn empties the pipe and skid, clears lit count,
//   sample counter, empty run and mode (normal), and loads register defaults.
module frame_empty_screen_blanker
    import fesb_pkg::*;
#(
    parameter int unsigned MAX_FRAME_PIXELS = 2097152
) (
    input  logic             aclk,
    input  logic             aresetn,
    // pixel stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic             s_tlast,   // last_pixel
    // per-frame results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] screen_blanked, [1] turn_off, [2] turn_on,
                                        // [3] frame_empty, [5:4] mode, [7:6] zero
    // register writes
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // Lit counter saturates at the smaller of the frame size and the counter range
    localparam logic [LIT_W-1:0] LIT_CAP =
        (MAX_FRAME_PIXELS < 4194303) ? LIT_W'(MAX_FRAME_PIXELS) : LIT_MAX;

    // ---------------- configuration registers ----------------
    logic [7:0]       pixel_level_reg;
    logic [LIT_W-1:0] pixel_count_limit_reg;
    seq_cfg_t         seq_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_level_reg                   <= 8'd128;
            pixel_count_limit_reg             <= 22'd1000;
            seq_cfg_reg.coarse_run_every      <= 16'd30;
            seq_cfg_reg.coarse_threshold      <= 16'd10;
            seq_cfg_reg.fine_run_every        <= 16'd1;
            seq_cfg_reg.fine_threshold        <= 16'd30;
        end else if (cfg_wr_en) begin
            // upper bits beyond each register width are dropped; unknown index ignored
            unique case (cfg_index)
                REG_PIXEL_LEVEL:       pixel_level_reg <= cfg_wdata[7:0];
                REG_PIXEL_COUNT_LIMIT: pixel_count_limit_reg <= cfg_wdata[LIT_W-1:0];
                REG_COARSE_RUN_EVERY:  seq_cfg_reg.coarse_run_every <= cfg_wdata[CNT_W-1:0];
                REG_COARSE_THRESHOLD:  seq_cfg_reg.coarse_threshold <= cfg_wdata[CNT_W-1:0];
                REG_FINE_RUN_EVERY:    seq_cfg_reg.fine_run_every <= cfg_wdata[CNT_W-1:0];
                REG_FINE_THRESHOLD:    seq_cfg_reg.fine_threshold <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Whole pipe moves unless the skid entry holds a result. Since ready only
    // depends on a register, nothing combinational runs from m_tready to s_tready.
    logic advance;
    logic skid_valid_reg;

    assign advance  = !skid_valid_reg;
    assign s_tready = advance;

    // ---------------- stage 1: input register ----------------
    logic       p1_valid_reg;
    logic [7:0] p1_red_reg, p1_green_reg, p1_blue_reg;
    logic       p1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_red_reg   <= s_tdata[7:0];
            p1_green_reg <= s_tdata[15:8];
            p1_blue_reg  <= s_tdata[23:16];
            p1_last_reg  <= s_tlast;
        end
    end

    // ---------------- stage 2: gray and lit compare ----------------
    logic [SUM_W-1:0] gray_sum;
    logic [7:0]       gray;
    logic             p2_valid_reg;
    logic             p2_lit_reg;
    logic             p2_last_reg;

    // constant-weight products; the rounded sum stays below 2^22
    assign gray_sum = {14'd0, p1_red_reg}   * GRAY_R_WEIGHT
                    + {14'd0, p1_green_reg} * GRAY_G_WEIGHT
                    + {14'd0, p1_blue_reg}  * GRAY_B_WEIGHT
                    + GRAY_ROUND;
    assign gray = gray_sum[SUM_W-1:14];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p2_lit_reg  <= (gray > pixel_level_reg);
            p2_last_reg <= p1_last_reg;
        end
    end

    // ---------------- stage 3: lit count and sequencer ----------------
    logic [LIT_W-1:0] lit_cnt_reg;
    logic [LIT_W-1:0] lit_cnt_next;
    seq_state_t       seq_reg;
    seq_state_t       seq_next;
    seq_flags_t       flags;
    logic             frame_empty;
    logic             pix_go;
    logic             res_valid;
    logic [7:0]       res_data;

    assign pix_go       = advance && p2_valid_reg;
    assign res_valid    = pix_go && p2_last_reg;
    // last pixel is counted before the frame is judged
    assign lit_cnt_next = (p2_lit_reg && (lit_cnt_reg < LIT_CAP)) ? lit_cnt_reg + 1'b1
                                                                  : lit_cnt_reg;
    assign frame_empty  = (lit_cnt_next < pixel_count_limit_reg);

    fesb_seq u_seq (
        .state_cur   (seq_reg),
        .cfg         (seq_cfg_reg),
        .frame_empty (frame_empty),
        .state_nxt   (seq_next),
        .flags       (flags)
    );

    assign res_data = {2'b00, seq_next.mode, frame_empty,
                       flags.turn_on, flags.turn_off, flags.screen_blanked};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_cnt_reg <= '0;
            seq_reg     <= '{mode: MODE_NORMAL, sample_cnt: '0, empty_run: '0};
        end else if (pix_go) begin
            if (p2_last_reg) begin
                lit_cnt_reg <= '0;
                seq_reg     <= seq_next;
            end else begin
                lit_cnt_reg <= lit_cnt_next;
            end
        end
    end

    // ---------------- output register and skid entry ----------------
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [7:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            // output slot frees up: drain skid first (pipe is frozen while it is full)
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end
        if (out_valid_reg && !m_tready && res_valid) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/fesb_checker.sv =====
// Port-level checks for the screen blanker, bound to the top level.
module fesb_checker
    import fesb_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [7:0]       m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // switch-off only lands on an empty frame that enters fine mode blanked
    a_turn_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |->
            m_tdata[0] && m_tdata[3] && !m_tdata[2] && (m_tdata[5:4] == MODE_FINE))
        else $error("turn_off without blank in fine mode");

    // restore only on a lit frame that returns to normal mode
    a_turn_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |->
            !m_tdata[0] && !m_tdata[3] && (m_tdata[5:4] == MODE_NORMAL))
        else $error("turn_on outside a restore to normal");

    // blanked only reported from fine mode; padding and unused mode code never show
    a_blank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:6] == 2'b00) && (m_tdata[5:4] != 2'd3) &&
            (!m_tdata[0] || (m_tdata[5:4] == MODE_FINE)))
        else $error("bad result encoding");

endmodule

bind frame_empty_screen_blanker fesb_checker u_fesb_checker (.*);

// ===== bench/tb.sv =====
// Testbench for the empty-frame screen blanker: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
    import fesb_pkg::*;

    localparam int unsigned N_PIXELS = 1450;
    // lit count ceiling: smaller of MAX_FRAME_PIXELS and the 22-bit counter max
    localparam int unsigned LIT_CAP  = 2097152;
    // indexes past the last register, the block must ignore them
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    // one result beat, lowest bit last in the list
    typedef struct packed {
        logic [1:0] pad;
        logic [1:0] mode;
        logic       frame_empty;
        logic       turn_on;
        logic       turn_off;
        logic       screen_blanked;
    } frame_verdict_t;

    typedef enum logic [1:0] { SMP_WAIT, SMP_LIT, SMP_EMPTY } sample_outcome_t;
    typedef enum logic { ROW_PIXEL, ROW_REG } row_kind_t;

    // directed stimulus row: either a register write or a pixel beat
    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] val;
        logic [23:0]      pix;      // {blue, green, red}
        logic             last;
        logic             typed;    // want holds a hand-written expectation
        logic [7:0]       want;
    } row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    frame_empty_screen_blanker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop in case a handshake hangs
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state, register copies start at their reset values
    // ------------------------------------------------------------------
    logic [7:0]       lvl      = 8'd128;
    logic [LIT_W-1:0] lim      = 22'd1000;
    logic [CNT_W-1:0] c_every  = 16'd30;
    logic [CNT_W-1:0] c_thr    = 16'd10;
    logic [CNT_W-1:0] f_every  = 16'd1;
    logic [CNT_W-1:0] f_thr    = 16'd30;
    mode_t            mode_q   = MODE_NORMAL;
    logic [CNT_W-1:0] smp_cnt  = '0;
    logic [CNT_W-1:0] run_len  = '0;
    logic [LIT_W-1:0] lit_cnt  = '0;

    frame_verdict_t   verdict_q[$];   // expected result beats, oldest first
    row_t             plan_q[$];      // directed table
    int unsigned      n_pix = 0;
    int unsigned      n_bad = 0;
    bit               tx_quiet = 1'b0;
    bit               rx_quiet = 1'b0;

    // bits above a register's width are dropped, unknown indexes ignored
    function automatic void reg_write_model(input logic [IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] val);
        case (idx)
            REG_PIXEL_LEVEL:       lvl     = val[7:0];
            REG_PIXEL_COUNT_LIMIT: lim     = val[LIT_W-1:0];
            REG_COARSE_RUN_EVERY:  c_every = val[CNT_W-1:0];
            REG_COARSE_THRESHOLD:  c_thr   = val[CNT_W-1:0];
            REG_FINE_RUN_EVERY:    f_every = val[CNT_W-1:0];
            REG_FINE_THRESHOLD:    f_thr   = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // shared sample counter and empty-run counter, both saturating
    function automatic sample_outcome_t sampler_tick(input logic empty,
                                                     input logic [CNT_W-1:0] period,
                                                     input logic [CNT_W-1:0] thr);
        if (smp_cnt < CNT_MAX) smp_cnt++;
        if (smp_cnt < period) return SMP_WAIT;
        smp_cnt = '0;
        if (!empty) begin
            run_len = '0;
            return SMP_LIT;
        end
        if (run_len < CNT_MAX) run_len++;
        return (run_len >= thr) ? SMP_EMPTY : SMP_WAIT;
    endfunction

    // one pixel in; returns 1 with the verdict when the pixel closes a frame
    function automatic bit pixel_in(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic last,
                                    output frame_verdict_t v);
        int unsigned     gray;
        logic            empty;
        sample_outcome_t o;
        gray = (32'(r) * GRAY_R_WEIGHT + 32'(g) * GRAY_G_WEIGHT
              + 32'(b) * GRAY_B_WEIGHT + GRAY_ROUND) >> 14;
        v = '0;
        if (gray > lvl && lit_cnt < LIT_CAP) lit_cnt++;
        if (!last) return 1'b0;
        empty   = (lit_cnt < lim);
        lit_cnt = '0;
        case (mode_q)
            MODE_NORMAL: begin
                if (sampler_tick(empty, c_every, c_thr) == SMP_EMPTY) begin
                    mode_q  = MODE_COARSE;
                    run_len = '0;
                end
            end
            MODE_COARSE: begin
                o = sampler_tick(empty, f_every, f_thr);
                if (o == SMP_EMPTY) begin
                    mode_q           = MODE_FINE;
                    v.turn_off       = 1'b1;
                    v.screen_blanked = 1'b1;
                end else if (o == SMP_LIT) begin
                    mode_q  = MODE_NORMAL;
                    run_len = '0;
                end
            end
            MODE_FINE: begin
                if (empty) begin
                    v.screen_blanked = 1'b1;
                end else begin
                    mode_q    = MODE_NORMAL;
                    run_len   = '0;
                    v.turn_on = 1'b1;
                end
            end
            default: ;
        endcase
        v.frame_empty = empty;
        v.mode        = mode_q;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int sel;
        if (quiet) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // dark pixels mostly stay at or below the level, bright ones above it;
    // a weighted average with unit weight sum never leaves [min, max]
    function automatic logic [23:0] pick_pixel(input bit dark);
        logic [7:0] c[3];
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return 24'($urandom());
        if (sel == 1) return '0;
        if (sel == 2) return '1;
        for (int i = 0; i < 3; i++) begin
            if (dark) c[i] = 8'($urandom_range(0, lvl));
            else if (lvl == 8'd255) c[i] = 8'($urandom());
            else c[i] = 8'($urandom_range(lvl + 1, 255));
        end
        return {c[2], c[1], c[0]};
    endfunction

    // small values most of the time so the sequencer walks all modes
    function automatic logic [CFG_W-1:0] pick_reg_value(input logic [IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        int sel;
        sel = $urandom_range(0, 9);
        v   = CFG_W'($urandom());
        case (idx)
            REG_PIXEL_LEVEL: begin
                if (sel == 0) v[7:0] = 8'd0;
                else if (sel == 1) v[7:0] = 8'd255;
                if ($urandom_range(0, 3) != 0) v[CFG_W-1:8] = '0;
            end
            REG_PIXEL_COUNT_LIMIT: begin
                if (sel == 0) v = 22'h200000;
                else if (sel == 1) v = '1;
                else if (sel > 2) v = CFG_W'($urandom_range(0, 4));
            end
            REG_COARSE_RUN_EVERY, REG_FINE_RUN_EVERY: begin
                if (sel == 0) v[CNT_W-1:0] = '1;
                else if (sel > 1) v[CNT_W-1:0] = CNT_W'($urandom_range(0, 3));
                if ($urandom_range(0, 3) != 0) v[CFG_W-1:CNT_W] = '0;
            end
            REG_COARSE_THRESHOLD, REG_FINE_THRESHOLD: begin
                if (sel == 0) v[CNT_W-1:0] = '1;
                else if (sel > 1) v[CNT_W-1:0] = CNT_W'($urandom_range(0, 5));
                if ($urandom_range(0, 3) != 0) v[CFG_W-1:CNT_W] = '0;
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_px(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic last,
                                   input logic typed = 1'b0, input logic [7:0] want = '0);
        row_t row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.pix   = {b, g, r};
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        plan_q.push_back(row);
    endfunction

    function automatic void add_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        row_t row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.val  = val;
        plan_q.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One pixel beat. Entered just after aclk rises; tvalid is only
    // dropped when a gap is taken, so it stays high while the beat waits for s_tready.
    task automatic push_pixel(input logic [23:0] pix, input logic last,
                              input logic typed, input logic [7:0] want);
        int             gap;
        frame_verdict_t v;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // beat taken at this edge
        if (pixel_in(pix[7:0], pix[15:8], pix[23:16], last, v))
            verdict_q.push_back(typed ? frame_verdict_t'(want) : v);
        n_pix++;
    endtask

    // write strobe stays high across back-to-back writes; caller drops it
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        reg_write_model(idx, val);
    endtask

    // Block idle: all verdicts in, then an idle wait so any pixel still
    // in the three-stage pipe has cleared before a register changes.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, stretches of none in quiet phases
    // ------------------------------------------------------------------
    int rdy_left = 0;
    int rx_stall;

    always @(posedge aclk) begin
        if (rdy_left != 0) begin
            rdy_left <= rdy_left - 1;
        end else if (m_tready) begin
            rx_stall = pick_gap(rx_quiet);
            if (rx_stall != 0) begin
                m_tready <= 1'b0;
                rdy_left <= rx_stall - 1;
            end else begin
                rdy_left <= $urandom_range(0, 7);
            end
        end else begin
            m_tready <= 1'b1;
            rdy_left <= $urandom_range(0, 11);
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    frame_verdict_t got, expd;
    string          diffs;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = frame_verdict_t'(m_tdata);
            if (verdict_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("tb: unexpected result beat %h at %0t", m_tdata, $realtime);
            end else begin
                expd  = verdict_q.pop_front();
                diffs = "";
                if (got.screen_blanked !== expd.screen_blanked) diffs = {diffs, " screen_blanked"};
                if (got.turn_off !== expd.turn_off)             diffs = {diffs, " turn_off"};
                if (got.turn_on !== expd.turn_on)               diffs = {diffs, " turn_on"};
                if (got.frame_empty !== expd.frame_empty)       diffs = {diffs, " frame_empty"};
                if (got.mode !== expd.mode)                     diffs = {diffs, " mode"};
                if (got.pad !== 2'b00)                          diffs = {diffs, " pad"};
                if (diffs != "") begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("tb: mismatch at %0t:%s expected %h got %h", $realtime,
                                 diffs, expd, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        row_t             row;
        logic             writing;
        logic [IDX_W-1:0] idx;
        int               nframes;
        int               flen;
        int               nwr;
        bit               dark;

        // Directed table. With reset defaults a tiny frame is always empty
        // and the normal-mode period is far off: verdict is just frame_empty.
        add_px(8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'h08);
        add_px(8'd255, 8'd255, 8'd255, 1'b0);
        add_px(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'h08);
        // spare indexes must not disturb anything
        add_reg(REG_SPARE_A, '1);
        add_reg(REG_SPARE_B, 22'h000015);
        // every frame sampled, short thresholds: walk normal, coarse, fine, back
        add_reg(REG_PIXEL_LEVEL, 22'd0);
        add_reg(REG_PIXEL_COUNT_LIMIT, 22'd1);
        add_reg(REG_COARSE_RUN_EVERY, 22'd0);
        add_reg(REG_COARSE_THRESHOLD, 22'h3F0002);   // high bits dropped
        add_reg(REG_FINE_RUN_EVERY, 22'd1);
        add_reg(REG_FINE_THRESHOLD, 22'd1);
        add_px(8'd0,   8'd0,   8'd0, 1'b1);          // empty, run of one
        add_px(8'd1,   8'd0,   8'd0, 1'b1);          // gray 0: into coarse
        add_px(8'd0,   8'd0,   8'd1, 1'b1);          // screen off, fine
        add_px(8'd0,   8'd0,   8'd0, 1'b1);          // stays blanked
        add_px(8'd0,   8'd2,   8'd0, 1'b1);          // gray 1: restore
        add_px(8'd255, 8'd0,   8'd0, 1'b1);          // lit, run cleared
        // level at top: nothing can be lit
        add_reg(REG_PIXEL_LEVEL, 22'd255);
        add_px(8'd255, 8'd255, 8'd255, 1'b1);
        // limit zero: nothing can be empty
        add_reg(REG_PIXEL_COUNT_LIMIT, 22'd0);
        add_px(8'd0,   8'd0,   8'd0, 1'b1);
        add_reg(REG_PIXEL_COUNT_LIMIT, 22'h200000);
        add_reg(REG_COARSE_RUN_EVERY, 22'hFFFF);
        add_reg(REG_FINE_RUN_EVERY, 22'd0);
        add_reg(REG_FINE_THRESHOLD, 22'hFFFF);
        add_reg(REG_PIXEL_LEVEL, 22'd128);
        add_px(8'd0,   8'd255, 8'd0,   1'b0);
        add_px(8'd0,   8'd0,   8'd255, 1'b1);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        writing = 1'b0;
        foreach (plan_q[i]) begin
            row = plan_q[i];
            if (row.kind == ROW_REG) begin
                if (!writing) settle();
                cfg_write(row.idx, row.val);
                writing = 1'b1;
            end else begin
                if (writing) cfg_wr_en <= 1'b0;
                writing = 1'b0;
                push_pixel(row.pix, row.last, row.typed, row.want);
            end
        end

        // Random phases: a few register writes on an idle block, then a burst
        // of frames. Dark and bright frames come in runs so the empty count
        // climbs through both thresholds; frames are mostly short.
        dark = 1'b1;
        while (n_pix < N_PIXELS) begin
            settle();
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            nwr = $urandom_range(1, 4);
            repeat (nwr) begin
                idx = IDX_W'($urandom_range(0, 7));
                cfg_write(idx, pick_reg_value(idx));
            end
            cfg_wr_en <= 1'b0;
            nframes = $urandom_range(6, 30);
            repeat (nframes) begin
                if ($urandom_range(0, 3) == 0) dark = !dark;
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24)
                                                   : $urandom_range(1, 4);
                for (int k = 1; k <= flen; k++)
                    push_pixel(pick_pixel(dark), k == flen, 1'b0, 8'h00);
            end
        end

        settle();
        if (verdict_q.size() != 0) begin
            n_bad++;
            $display("tb: %0d expected result beats never arrived", verdict_q.size());
        end
        if (n_bad == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
